// ===== hdl/bba_pkg.sv =====
// Package for the buddy block allocator: sizes, codes, command and status types.
package bba_pkg;

  localparam int TOP_ORDER    = 10;
  localparam int UNIT_BYTES   = 16;
  localparam int HEADER_BYTES = 8;

  localparam int NUNITS  = 1 << TOP_ORDER;
  localparam int IDX_W   = 10;
  localparam int LINK_W  = 11;
  localparam int ORD_W   = 4;
  localparam int REQ_W   = 16;
  localparam int TOT_W   = 17;
  localparam int BYTES_W = 15;
  localparam int LIVE_W  = 11;
  localparam int STAT_W  = 3;

  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
  localparam logic [LIVE_W-1:0]  LIVE_MAX  = '1;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_ZERO      = 3'd1;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_MEM    = 3'd3;
  localparam logic [STAT_W-1:0] ST_FREED     = 3'd4;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD,
    OP_DECODE,
    OP_SEARCH_INC,
    OP_SPLIT_SET,
    OP_UL_READ,
    OP_UL_APPLY,
    OP_PLO_SET,
    OP_PHI_SET,
    OP_PS0,
    OP_PS1,
    OP_CUR_DEC,
    OP_GNT_SET,
    OP_GNT_FIN,
    OP_FCHK,
    OP_MRD,
    OP_MMERGE,
    OP_FPUSH_SET,
    OP_FREE_FIN,
    OP_FIN_ERR
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STAT_W-1:0] stat;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic req_zero;
    logic too_large;
    logic cur_over;
    logic head_empty;
    logic cur_gt_ord;
    logic hdr_free;
    logic ord_top;
    logic bud_match;
    logic clr_done;
  } sts_t;

  // A link holds index plus one; zero means no neighbor.
  function automatic logic [IDX_W-1:0] link_to_idx(logic [LINK_W-1:0] l);
    logic [LINK_W-1:0] d;
    d = l - 1'b1;
    return d[IDX_W-1:0];
  endfunction

  function automatic logic [LINK_W-1:0] idx_to_link(logic [IDX_W-1:0] i);
    return {1'b0, i} + 1'b1;
  endfunction

  function automatic logic [BYTES_W-1:0] blk_bytes(logic [ORD_W-1:0] o);
    return BYTES_W'(UNIT_BYTES) << o;
  endfunction

endpackage

// ===== hdl/bba_datapath.sv =====
// Datapath of the buddy block allocator: header and link memories, list heads, counters.
module bba_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bba_pkg::cmd_t                cmd,
  input  logic                         in_opcode,
  input  logic [15:0]                  in_request_bytes,
  input  logic [9:0]                   in_block_index,
  output bba_pkg::sts_t                sts,
  output logic [bba_pkg::STAT_W-1:0]   out_status,
  output logic [bba_pkg::IDX_W-1:0]    out_granted_index,
  output logic [bba_pkg::ORD_W-1:0]    out_granted_order,
  output logic [bba_pkg::BYTES_W-1:0]  out_bytes_used,
  output logic [bba_pkg::LIVE_W-1:0]   out_live_blocks
);
  import bba_pkg::*;

  logic               op_free_r;
  logic [REQ_W-1:0]   req_r;
  logic [IDX_W-1:0]   b_r, ub_r, clr_r;
  logic [ORD_W-1:0]   ord_r, cur_r, uord_r;
  logic [LINK_W-1:0]  head_r [TOP_ORDER+1];
  logic [BYTES_W-1:0] bytes_r;
  logic [LIVE_W-1:0]  live_r;
  logic [STAT_W-1:0]  stat_r;
  logic [IDX_W-1:0]   gidx_r;
  logic [ORD_W-1:0]   gord_r;

  logic               mem_free [NUNITS];
  logic [ORD_W-1:0]   mem_ord  [NUNITS];
  logic [LINK_W-1:0]  mem_next [NUNITS];
  logic [LINK_W-1:0]  mem_prev [NUNITS];
  logic               free_rd_r;
  logic [ORD_W-1:0]   ord_rd_r;
  logic [LINK_W-1:0]  next_rd_r, prev_rd_r;

  logic               free_we, ord_we, next_we, prev_we;
  logic [IDX_W-1:0]   free_wa, ord_wa, next_wa, prev_wa, hdr_ra;
  logic               free_wd;
  logic [ORD_W-1:0]   ord_wd;
  logic [LINK_W-1:0]  next_wd, prev_wd;

  logic [TOT_W-1:0]   total;
  logic [ORD_W-1:0]   dec_ord, ord_clamp;
  logic [IDX_W-1:0]   bud, hi_idx, lo_idx;
  logic [LINK_W-1:0]  push_head;
  logic [BYTES_W:0]   bytes_sum;
  logic [BYTES_W-1:0] alloc_sz, free_sz;

  // Smallest order whose block covers the request plus header.
  always_comb begin
    total   = {1'b0, req_r} + TOT_W'(HEADER_BYTES);
    dec_ord = ORD_W'(TOP_ORDER + 1);
    for (int o = TOP_ORDER; o >= 0; o--) begin
      if ((TOT_W'(UNIT_BYTES) << o) >= total) dec_ord = ORD_W'(o);
    end
  end

  assign ord_clamp = (ord_rd_r > ORD_W'(TOP_ORDER)) ? ORD_W'(TOP_ORDER) : ord_rd_r;
  assign bud       = b_r ^ (IDX_W'(1) << ord_r);
  assign hi_idx    = (ub_r > b_r) ? ub_r : b_r;
  assign lo_idx    = (ub_r < b_r) ? ub_r : b_r;
  assign push_head = head_r[uord_r];
  assign hdr_ra    = (cmd.op == OP_MRD) ? bud : b_r;
  assign alloc_sz  = blk_bytes(ord_r);
  assign free_sz   = blk_bytes(ord_clamp);
  assign bytes_sum = {1'b0, bytes_r} + {1'b0, alloc_sz};

  always_comb begin
    free_we = 1'b0; free_wa = ub_r; free_wd = 1'b0;
    ord_we  = 1'b0; ord_wa  = ub_r; ord_wd  = uord_r;
    next_we = 1'b0; next_wa = ub_r; next_wd = '0;
    prev_we = 1'b0; prev_wa = ub_r; prev_wd = '0;
    case (cmd.op)
      OP_CLEAR: begin
        free_we = 1'b1; free_wa = clr_r; free_wd = (clr_r == '0);
        ord_we  = 1'b1; ord_wa  = clr_r;
        ord_wd  = (clr_r == '0) ? ORD_W'(TOP_ORDER) : '0;
        next_we = 1'b1; next_wa = clr_r;
        prev_we = 1'b1; prev_wa = clr_r;
      end
      OP_PS0: begin
        next_we = 1'b1; next_wd = push_head;
        if (push_head != '0) begin
          prev_we = 1'b1;
          prev_wa = link_to_idx(push_head);
          prev_wd = idx_to_link(ub_r);
        end
      end
      OP_PS1: begin
        prev_we = 1'b1;
        free_we = 1'b1; free_wd = 1'b1;
        ord_we  = 1'b1;
      end
      OP_UL_APPLY: begin
        if (next_rd_r != '0) begin
          prev_we = 1'b1; prev_wa = link_to_idx(next_rd_r); prev_wd = prev_rd_r;
        end
        if (prev_rd_r != '0) begin
          next_we = 1'b1; next_wa = link_to_idx(prev_rd_r); next_wd = next_rd_r;
        end
      end
      OP_GNT_FIN: begin
        free_we = 1'b1;
        ord_we  = 1'b1; ord_wd = ord_r;
      end
      OP_MMERGE: begin
        free_we = 1'b1; free_wa = hi_idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (free_we) mem_free[free_wa] <= free_wd;
    if (ord_we)  mem_ord[ord_wa]   <= ord_wd;
    if (next_we) mem_next[next_wa] <= next_wd;
    if (prev_we) mem_prev[prev_wa] <= prev_wd;
    free_rd_r <= mem_free[hdr_ra];
    ord_rd_r  <= mem_ord[hdr_ra];
    next_rd_r <= mem_next[ub_r];
    prev_rd_r <= mem_prev[ub_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= TOP_ORDER; i++) begin
        head_r[i] <= (i == TOP_ORDER) ? idx_to_link('0) : '0;
      end
      bytes_r <= '0;
      live_r  <= '0;
      clr_r   <= '1;
    end else begin
      case (cmd.op)
        OP_CLEAR: clr_r <= clr_r - 1'b1;
        OP_LOAD: begin
          op_free_r <= in_opcode;
          req_r     <= in_request_bytes;
          b_r       <= in_block_index;
        end
        OP_DECODE: begin
          ord_r <= dec_ord;
          cur_r <= dec_ord;
        end
        OP_SEARCH_INC: cur_r <= cur_r + 1'b1;
        OP_SPLIT_SET: begin
          b_r    <= link_to_idx(head_r[cur_r]);
          ub_r   <= link_to_idx(head_r[cur_r]);
          uord_r <= cur_r;
        end
        OP_UL_APPLY: begin
          if (prev_rd_r == '0) head_r[uord_r] <= next_rd_r;
        end
        OP_PLO_SET: uord_r <= cur_r - 1'b1;
        OP_PHI_SET: ub_r <= b_r + (IDX_W'(1) << (cur_r - 1'b1));
        OP_PS1: head_r[uord_r] <= idx_to_link(ub_r);
        OP_CUR_DEC: cur_r <= cur_r - 1'b1;
        OP_GNT_SET: begin
          ub_r   <= link_to_idx(head_r[ord_r]);
          uord_r <= ord_r;
        end
        OP_GNT_FIN: begin
          stat_r  <= ST_OK;
          gidx_r  <= ub_r;
          gord_r  <= ord_r;
          bytes_r <= (bytes_sum > {1'b0, BYTES_MAX}) ? BYTES_MAX : bytes_sum[BYTES_W-1:0];
          if (live_r != LIVE_MAX) live_r <= live_r + 1'b1;
        end
        OP_FCHK: begin
          ord_r   <= ord_clamp;
          bytes_r <= (bytes_r > free_sz) ? bytes_r - free_sz : '0;
          if (live_r != '0) live_r <= live_r - 1'b1;
        end
        OP_MRD: begin
          ub_r   <= bud;
          uord_r <= ord_r;
        end
        OP_MMERGE: begin
          b_r   <= lo_idx;
          ord_r <= ord_r + 1'b1;
        end
        OP_FPUSH_SET: begin
          ub_r   <= b_r;
          uord_r <= ord_r;
        end
        OP_FREE_FIN: begin
          stat_r <= ST_OK;
          gidx_r <= '0;
          gord_r <= '0;
        end
        OP_FIN_ERR: begin
          stat_r <= cmd.stat;
          gidx_r <= '0;
          gord_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    sts.is_free    = op_free_r;
    sts.req_zero   = (req_r == '0);
    sts.too_large  = (dec_ord > ORD_W'(TOP_ORDER));
    sts.cur_over   = (cur_r > ORD_W'(TOP_ORDER));
    sts.head_empty = sts.cur_over ? 1'b1 : (head_r[cur_r] == '0);
    sts.cur_gt_ord = (cur_r > ord_r);
    sts.hdr_free   = free_rd_r;
    sts.ord_top    = (ord_r >= ORD_W'(TOP_ORDER));
    sts.bud_match  = free_rd_r && (ord_rd_r == ord_r);
    sts.clr_done   = (clr_r == '0);
  end

  assign out_status        = stat_r;
  assign out_granted_index = gidx_r;
  assign out_granted_order = gord_r;
  assign out_bytes_used    = bytes_r;
  assign out_live_blocks   = live_r;

endmodule

// ===== hdl/bba_controller.sv =====
// Controller state machine of the buddy block allocator.
module bba_controller (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_strobe
);
  import bba_pkg::*;

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DISP  = 5'd2;
  localparam logic [4:0] S_DEC   = 5'd3;
  localparam logic [4:0] S_SRCH  = 5'd4;
  localparam logic [4:0] S_UL0   = 5'd5;
  localparam logic [4:0] S_UL1   = 5'd6;
  localparam logic [4:0] S_SPLO  = 5'd7;
  localparam logic [4:0] S_SPHI  = 5'd8;
  localparam logic [4:0] S_PS0   = 5'd9;
  localparam logic [4:0] S_PS1   = 5'd10;
  localparam logic [4:0] S_SDEC  = 5'd11;
  localparam logic [4:0] S_GFIN  = 5'd12;
  localparam logic [4:0] S_FRD   = 5'd13;
  localparam logic [4:0] S_FCHK  = 5'd14;
  localparam logic [4:0] S_MCHK  = 5'd15;
  localparam logic [4:0] S_MCMP  = 5'd16;
  localparam logic [4:0] S_MMRG  = 5'd17;
  localparam logic [4:0] S_FFIN  = 5'd18;
  localparam logic [4:0] S_ERR   = 5'd19;
  localparam logic [4:0] S_DONE  = 5'd20;

  logic [4:0]        state_r, state_nxt, ret_r, ret_nxt;
  logic [STAT_W-1:0] err_r, err_nxt;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    err_nxt   = err_r;
    cmd.op    = OP_NOP;
    cmd.stat  = err_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: state_nxt = sts.is_free ? S_FRD : S_DEC;
      S_DEC: begin
        cmd.op = OP_DECODE;
        if (sts.req_zero) begin
          err_nxt = ST_ZERO;   state_nxt = S_ERR;
        end else if (sts.too_large) begin
          err_nxt = ST_TOO_LARGE; state_nxt = S_ERR;
        end else begin
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (sts.cur_over) begin
          err_nxt = ST_NO_MEM; state_nxt = S_ERR;
        end else if (sts.head_empty) begin
          cmd.op = OP_SEARCH_INC;
        end else if (sts.cur_gt_ord) begin
          cmd.op = OP_SPLIT_SET; ret_nxt = S_SPLO; state_nxt = S_UL0;
        end else begin
          cmd.op = OP_GNT_SET; ret_nxt = S_GFIN; state_nxt = S_UL0;
        end
      end
      S_UL0: begin
        cmd.op = OP_UL_READ; state_nxt = S_UL1;
      end
      S_UL1: begin
        cmd.op = OP_UL_APPLY; state_nxt = ret_r;
      end
      S_SPLO: begin
        cmd.op = OP_PLO_SET; ret_nxt = S_SPHI; state_nxt = S_PS0;
      end
      S_SPHI: begin
        cmd.op = OP_PHI_SET; ret_nxt = S_SDEC; state_nxt = S_PS0;
      end
      S_PS0: begin
        cmd.op = OP_PS0; state_nxt = S_PS1;
      end
      S_PS1: begin
        cmd.op = OP_PS1; state_nxt = ret_r;
      end
      S_SDEC: begin
        cmd.op = OP_CUR_DEC; state_nxt = S_SRCH;
      end
      S_GFIN: begin
        cmd.op = OP_GNT_FIN; state_nxt = S_DONE;
      end
      S_FRD: state_nxt = S_FCHK;
      S_FCHK: begin
        if (sts.hdr_free) begin
          err_nxt = ST_FREED; state_nxt = S_ERR;
        end else begin
          cmd.op = OP_FCHK; state_nxt = S_MCHK;
        end
      end
      S_MCHK: begin
        if (sts.ord_top) begin
          cmd.op = OP_FPUSH_SET; ret_nxt = S_FFIN; state_nxt = S_PS0;
        end else begin
          cmd.op = OP_MRD; state_nxt = S_MCMP;
        end
      end
      S_MCMP: begin
        if (sts.bud_match) begin
          ret_nxt = S_MMRG; state_nxt = S_UL0;
        end else begin
          cmd.op = OP_FPUSH_SET; ret_nxt = S_FFIN; state_nxt = S_PS0;
        end
      end
      S_MMRG: begin
        cmd.op = OP_MMERGE; state_nxt = S_MCHK;
      end
      S_FFIN: begin
        cmd.op = OP_FREE_FIN; state_nxt = S_DONE;
      end
      S_ERR: begin
        cmd.op = OP_FIN_ERR; state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ret_r   <= S_IDLE;
      err_r   <= ST_OK;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      err_r   <= err_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_DONE);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request accepted but block not busy");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result strobe longer than one cycle");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy) else $error("block not idle after result");
  a_no_strobe_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_strobe) else $error("result during clearing pass");

endmodule

// ===== hdl/buddy_block_allocator_core.sv =====
// Top level of the buddy block allocator: controller and datapath joined.
//
// Buddy allocator over a pool of 1024 sixteen-byte units. A request is taken
// when start is high and busy is low; its single result appears for exactly
// one cycle with out_strobe high, and the receiver cannot hold it off, so it
// must capture the result in that cycle. After reset the block runs a clearing
// pass over its header and link memories, during which busy stays high. The
// block works on one request at a time. An allocate searches the free lists
// upward from the order it needs and splits a larger block down until one of
// that order is free; a free rejects a block that is already free and else
// merges it with its buddy as long as the buddy is free and of the same order.
// After each result the block returns to idle, where the next request can be
// taken. The controller walks the header and link memories step by step for
// each unlink, push and buddy check. Status, bytes in use and live block count
// come with every result; granted index and order are zero for frees and for
// failed requests.
module buddy_block_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [15:0] in_request_bytes,
  input  logic [9:0]  in_block_index,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [9:0]  out_granted_index,
  output logic [3:0]  out_granted_order,
  output logic [14:0] out_bytes_used,
  output logic [10:0] out_live_blocks
);
  import bba_pkg::*;

  // The command goes from controller to datapath; status comes back.
  cmd_t cmd;
  sts_t sts;

  bba_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  bba_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_opcode         (in_opcode),
    .in_request_bytes  (in_request_bytes),
    .in_block_index    (in_block_index),
    .sts               (sts),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_granted_order (out_granted_order),
    .out_bytes_used    (out_bytes_used),
    .out_live_blocks   (out_live_blocks)
  );

endmodule

// ===== sim/bba_checker.sv =====
// Checker for the buddy block allocator: predicts each result and compares it.
module bba_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_opcode,
  input  logic [15:0] in_request_bytes,
  input  logic [9:0]  in_block_index,
  input  logic        out_strobe,
  input  logic [2:0]  out_status,
  input  logic [9:0]  out_granted_index,
  input  logic [3:0]  out_granted_order,
  input  logic [14:0] out_bytes_used,
  input  logic [10:0] out_live_blocks,
  output int          fail_count,
  output int          pending_count,
  output int          grants_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [IDX_W-1:0]   gidx;
    logic [ORD_W-1:0]   gord;
    logic [BYTES_W-1:0] bytes;
    logic [LIVE_W-1:0]  live;
  } alloc_result_t;

  logic              pool_free  [NUNITS];
  logic [ORD_W-1:0]  pool_order [NUNITS];
  logic [LINK_W-1:0] succ       [NUNITS];
  logic [LINK_W-1:0] pred       [NUNITS];
  logic [LINK_W-1:0] head       [TOP_ORDER+1];
  logic [BYTES_W-1:0] bytes_now;
  logic [LIVE_W-1:0]  live_now;
  alloc_result_t expected_results[$];
  logic          expected_ops[$];

  function automatic logic [IDX_W-1:0] to_idx(logic [LINK_W-1:0] l);
    logic [LINK_W-1:0] d;
    d = l - 1'b1;
    return d[IDX_W-1:0];
  endfunction

  function automatic void detach(logic [IDX_W-1:0] b, int ord);
    logic [LINK_W-1:0] nx;
    logic [LINK_W-1:0] pv;
    nx = succ[b];
    pv = pred[b];
    if (nx != 0) pred[to_idx(nx)] = pv;
    if (pv != 0) succ[to_idx(pv)] = nx;
    else head[ord] = nx;
  endfunction

  function automatic void attach(logic [IDX_W-1:0] b, int ord);
    logic [LINK_W-1:0] h;
    h = head[ord];
    succ[b] = h;
    if (h != 0) pred[to_idx(h)] = {1'b0, b} + 1'b1;
    pred[b] = '0;
    pool_order[b] = ORD_W'(ord);
    pool_free[b] = 1'b1;
    head[ord] = {1'b0, b} + 1'b1;
  endfunction

  function automatic void clear_pool();
    for (int i = 0; i < NUNITS; i++) begin
      pool_free[i] = 0; pool_order[i] = 0; succ[i] = 0; pred[i] = 0;
    end
    for (int i = 0; i <= TOP_ORDER; i++) head[i] = 0;
    bytes_now = 0;
    live_now = 0;
    attach('0, TOP_ORDER);
  endfunction

  // Runs one request through the allocator's bookkeeping.
  function automatic alloc_result_t allocate_or_free(logic op, logic [15:0] req,
                                                      logic [9:0] idx);
    alloc_result_t r;
    int total, ord, cur, sz, o;
    logic [IDX_W-1:0] b, bud, hi;
    r = '0;
    if (op == 1'b0) begin
      total = int'(req) + HEADER_BYTES;
      ord = TOP_ORDER + 1;
      if (req == 0) r.status = ST_ZERO;
      else begin
        for (o = TOP_ORDER; o >= 0; o--)
          if ((UNIT_BYTES << o) >= total) ord = o;
        if (ord > TOP_ORDER) r.status = ST_TOO_LARGE;
        else begin
          cur = ord;
          while (cur <= TOP_ORDER && head[cur] == 0) cur++;
          if (cur > TOP_ORDER) r.status = ST_NO_MEM;
          else begin
            while (cur > ord) begin
              b = to_idx(head[cur]);
              detach(b, cur);
              attach(b, cur - 1);
              attach(b + IDX_W'(1 << (cur - 1)), cur - 1);
              cur--;
            end
            b = to_idx(head[ord]);
            detach(b, ord);
            pool_free[b] = 0;
            pool_order[b] = ORD_W'(ord);
            r.status = ST_OK;
            r.gidx = b;
            r.gord = ORD_W'(ord);
            sz = int'(bytes_now) + (UNIT_BYTES << ord);
            bytes_now = (sz > int'(BYTES_MAX)) ? BYTES_MAX : BYTES_W'(sz);
            if (live_now != LIVE_MAX) live_now++;
          end
        end
      end
    end else if (pool_free[idx]) begin
      r.status = ST_FREED;
    end else begin
      b = idx;
      ord = pool_order[b];
      if (ord > TOP_ORDER) ord = TOP_ORDER;
      sz = UNIT_BYTES << ord;
      bytes_now = (int'(bytes_now) > sz) ? BYTES_W'(int'(bytes_now) - sz) : '0;
      if (live_now != 0) live_now--;
      while (ord < TOP_ORDER) begin
        bud = b ^ IDX_W'(1 << ord);
        if (!pool_free[bud] || pool_order[bud] != ORD_W'(ord)) break;
        detach(bud, ord);
        hi = (bud > b) ? bud : b;
        if (bud < b) b = bud;
        pool_free[hi] = 0;
        ord++;
      end
      attach(b, ord);
    end
    r.bytes = bytes_now;
    r.live = live_now;
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t e;
    alloc_result_t a;
    logic          op;
    if (!rst_n) begin
      clear_pool();
      expected_results.delete();
      expected_ops.delete();
      fail_count <= 0;
      grants_seen <= 0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(allocate_or_free(in_opcode, in_request_bytes,
                                                    in_block_index));
        expected_ops.push_back(in_opcode);
      end
      if (out_strobe) begin
        a = '{out_status, out_granted_index, out_granted_order, out_bytes_used,
              out_live_blocks};
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request outstanding: %h", $time, a);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          op = expected_ops.pop_front();
          if (e !== a) begin
            $display("%0t: mismatch status %0d/%0d idx %0d/%0d ord %0d/%0d", $time,
                     e.status, a.status, e.gidx, a.gidx, e.gord, a.gord);
            $display("%0t:   bytes %0d/%0d live %0d/%0d (expected/actual)", $time,
                     e.bytes, a.bytes, e.live, a.live);
            fail_count <= fail_count + 1;
          end
          // Only allocates that were granted a block are counted.
          if (a.status == ST_OK && !op) grants_seen <= grants_seen + 1;
        end
      end
    end
    pending_count = expected_results.size();
  end

  initial begin
    fail_count = 0;
    pending_count = 0;
    grants_seen = 0;
    clear_pool();
  end
endmodule

// ===== sim/tb.sv =====
// Testbench top for the buddy block allocator: stimulus, watchdog and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic        in_opcode = 0;
  logic [15:0] in_request_bytes = 0;
  logic [9:0]  in_block_index = 0;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic [9:0]  out_granted_index;
  logic [3:0]  out_granted_order;
  logic [14:0] out_bytes_used;
  logic [10:0] out_live_blocks;
  int          fail_count, pending_count, grants_seen;
  int          idle_pct = 0;
  int          quiet_cycles = 0;
  int          sent = 0;
  logic [9:0]  granted_pool[$];
  logic        in_opcode_last = 0;

  // The watchdog limit covers the clearing pass after reset plus a long sender gap.
  localparam int WATCHDOG = 20000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  buddy_block_allocator_core dut (.*);

  bba_checker chk (.*);

  // Remember granted blocks so that most frees name a live block.
  always @(posedge clk) if (start && !busy) in_opcode_last <= in_opcode;
  always @(posedge clk)
    if (out_strobe && out_status == ST_OK && !in_opcode_last)
      granted_pool.push_back(out_granted_index);

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Issues one request, holding start until busy is low. Start stays high
  // after acceptance unless the sender idles; the block is busy then.
  task automatic send_request(input logic op, input logic [15:0] req,
                              input logic [9:0] idx);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_opcode <= op;
    in_request_bytes <= req;
    in_block_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // Request sizes are mostly small so the pool holds many blocks at once.
  function automatic logic [15:0] pick_size();
    int k;
    k = $urandom_range(99, 0);
    if (k < 60) return 16'($urandom_range(200, 1));
    if (k < 85) return 16'($urandom_range(2000, 1));
    if (k < 92) return 16'($urandom_range(16376, 1));
    if (k < 96) return 16'($urandom_range(65535, 16377));
    return 16'($urandom);
  endfunction

  task automatic random_phase(input int pct, input int n);
    int k;
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99, 0);
      if (k < 55 || granted_pool.size() == 0)
        send_request(1'b0, pick_size(), 10'($urandom));
      else if (k < 93) begin
        int j;
        logic [9:0] blk;
        j = $urandom_range(granted_pool.size() - 1, 0);
        blk = granted_pool[j];
        granted_pool.delete(j);
        send_request(1'b1, 16'($urandom), blk);
      end else
        // Double frees and frees of indices that were never handed out.
        send_request(1'b1, 16'($urandom), 10'($urandom));
    end
  endtask

  initial begin
    int drain;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part: edge sizes, exhaustion, double free and a stray free.
    send_request(1'b0, 16'd0, 10'd0);
    send_request(1'b0, 16'hFFFF, 10'h3FF);
    send_request(1'b0, 16'd16377, 10'd0);
    send_request(1'b0, 16'd16376, 10'd0);
    send_request(1'b0, 16'd1, 10'd0);
    send_request(1'b1, 16'd0, 10'd0);
    send_request(1'b1, 16'd0, 10'd0);
    send_request(1'b1, 16'd0, 10'h3FF);
    send_request(1'b0, 16'd8, 10'd0);
    send_request(1'b0, 16'd9, 10'd0);
    send_request(1'b0, 16'd24, 10'd0);
    send_request(1'b0, 16'd8184, 10'd0);
    send_request(1'b0, 16'd8184, 10'd0);
    send_request(1'b1, 16'd0, 10'd0);
    send_request(1'b1, 16'd0, 10'd1);
    send_request(1'b1, 16'd0, 10'd2);
    send_request(1'b1, 16'd0, 10'd512);
    send_request(1'b1, 16'd0, 10'd513);
    send_request(1'b1, 16'hFFFF, 10'h155);
    send_request(1'b1, 16'h5555, 10'h2AA);
    granted_pool.delete();
    send_request(1'b0, 16'h5555, 10'h155);

    random_phase(0, 300);
    random_phase(83, 200);
    random_phase(13, 250);
    random_phase(0, 250);
    start <= 0;

    drain = 0;
    while (pending_count != 0 && drain < WATCHDOG) begin
      @(posedge clk);
      drain++;
    end
    repeat (200) @(posedge clk);
    $display("Sent %0d requests (allocates, frees, double and stray frees), %0d granted.",
             sent, grants_seen);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
